### hdl/bdsm_pkg.sv
package bdsm_pkg;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_BANDS_BITS  = 3;
    localparam int RESET_WIDTH     = 2048;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_BAND_COUNT    = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

endpackage

### hdl/box_downsample_2x2_valid_mean.sv
// 2x2 box downsampler for one image pyramid level. Source samples come in raster order with
// the bands of a pixel in a row, one sample per word on s_t*, its valid flag in s_tuser. For
// every 2x2 block and band one result word leaves on m_t*: the floor mean of the valid samples
// in the block (odd right or bottom edges use only the samples present), m_tuser low when no
// sample was valid, m_tlast on the last word of the frame. A sample is taken every clock unless
// stage 1 waits on a stalled output; the sample that closes a block goes by position decode,
// pair add and upper-line store read into the stage 1 registers, then the divide by 1 to 4 into
// the output register. The upper line of pairs is held in a single-port memory of MAX_WIDTH/2 by
// MAX_BANDS entries, which needs no clearing after reset. A write to any of the three
// registers restarts the frame at its first sample, a write to index 3 is ignored; write
// registers only while no word is in flight.
module box_downsample_2x2_valid_mean
    import bdsm_pkg::*;
#(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_BANDS   = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [CFG_DATA_BITS-1:0]            cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
    input  logic                                s_tuser,   // sample_valid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // average
    output logic                                m_tuser,   // average_valid
    output logic                                m_tlast
);

    localparam int DW     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SB     = SAMPLE_BITS;
    localparam int PSW    = SB + 1;
    localparam int SUMW   = SB + 2;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WEW    = $clog2(MAX_WIDTH + 1);
    localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int NBW    = $clog2(MAX_BANDS + 1);
    localparam int PAIRS  = (MAX_WIDTH + 1) / 2;
    localparam int PW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int AW     = PW + BW;
    localparam int DEPTH  = 2 ** AW;
    localparam int K      = SUMW + 2;
    localparam int PRODW  = SUMW + K;
    localparam logic [K-1:0] DIV3_MUL = K'(((64'd1 << K) + 64'd2) / 64'd3);
    localparam int RST_W  = (MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    typedef struct packed {
        logic [PSW-1:0] sum;
        logic [1:0]     cnt;
    } pair_t;

    // configuration, held saturated
    logic [WEW-1:0]             w_reg;
    logic [CFG_HEIGHT_BITS-1:0] h_reg;
    logic [NBW-1:0]             nb_reg;

    // stream position
    logic [CW-1:0]              col_reg, col_next;
    logic [CFG_HEIGHT_BITS-1:0] row_reg, row_next;
    logic [BW-1:0]              band_reg, band_next;

    logic [SB-1:0]              hold_sum_reg [MAX_BANDS];
    logic                       hold_cnt_reg [MAX_BANDS];

    pair_t                      line_mem [DEPTH];
    pair_t                      rd_reg;

    logic                       s1_valid_reg, s1_valid_next;
    pair_t                      s1_pair_reg;
    logic                       s1_upper_reg;
    logic                       s1_eof_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [SB-1:0]              avg_reg;
    logic                       avgv_reg;
    logic                       last_reg;

    logic                       accept;
    logic                       cfg_write;
    logic                       cfg_restart;
    logic                       out_free;
    logic                       s1_go;
    logic                       v_in;
    logic [SB-1:0]              s_in;
    logic [WEW:0]               col_inc;
    logic [CFG_HEIGHT_BITS:0]   row_inc;
    logic [NBW:0]               band_inc;
    logic                       last_col;
    logic                       last_row;
    logic                       last_band;
    logic                       pair_done;
    logic                       produce;
    logic                       mem_wr;
    pair_t                      pair;
    logic [AW-1:0]              addr;

    logic [SUMW-1:0]            blk_sum;
    logic [2:0]                 blk_cnt;
    logic [PRODW-1:0]           prod;
    logic [SB-1:0]              avg_calc;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid & cfg_ready;
    assign cfg_restart = cfg_write & (cfg_index != CFG_UNUSED);

    assign out_free = ~out_valid_reg | m_tready;
    assign s1_go    = s1_valid_reg & out_free;
    assign s_tready = ~s1_valid_reg | out_free;
    assign accept   = s_tvalid & s_tready;

    assign v_in = s_tuser;
    assign s_in = v_in ? s_tdata[SB-1:0] : '0;

    assign col_inc   = (WEW + 1)'(col_reg) + 1'b1;
    assign row_inc   = (CFG_HEIGHT_BITS + 1)'(row_reg) + 1'b1;
    assign band_inc  = (NBW + 1)'(band_reg) + 1'b1;
    assign last_col  = col_inc >= {1'b0, w_reg};
    assign last_row  = row_inc >= {1'b0, h_reg};
    assign last_band = band_inc >= {1'b0, nb_reg};

    assign addr = {PW'(col_reg >> 1), band_reg};

    always_comb
    begin
        if (col_reg[0] == 1'b0)
        begin
            pair.sum  = PSW'(s_in);
            pair.cnt  = {1'b0, v_in};
            pair_done = last_col;
        end
        else
        begin
            pair.sum  = PSW'(hold_sum_reg[band_reg]) + PSW'(s_in);
            pair.cnt  = {1'b0, hold_cnt_reg[band_reg]} + {1'b0, v_in};
            pair_done = 1'b1;
        end
    end

    assign produce = pair_done & (row_reg[0] | last_row);
    assign mem_wr  = accept & pair_done & ~row_reg[0] & ~last_row;

    // position counters
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        band_next = band_reg;
        if (cfg_restart)
        begin
            col_next  = '0;
            row_next  = '0;
            band_next = '0;
        end
        else if (accept)
        begin
            if (last_band)
            begin
                band_next = '0;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                band_next = band_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            band_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            band_reg <= band_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= WEW'(RST_W);
            h_reg  <= CFG_HEIGHT_BITS'(1);
            nb_reg <= NBW'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:
                begin
                    if (cfg_data[CFG_WIDTH_BITS-1:0] == '0)
                        w_reg <= WEW'(1);
                    else if (int'(cfg_data[CFG_WIDTH_BITS-1:0]) > MAX_WIDTH)
                        w_reg <= WEW'(MAX_WIDTH);
                    else
                        w_reg <= WEW'(cfg_data[CFG_WIDTH_BITS-1:0]);
                end
                CFG_SOURCE_HEIGHT:
                begin
                    h_reg <= (cfg_data[CFG_HEIGHT_BITS-1:0] == '0) ?
                             CFG_HEIGHT_BITS'(1) : cfg_data[CFG_HEIGHT_BITS-1:0];
                end
                CFG_BAND_COUNT:
                begin
                    if (cfg_data[CFG_BANDS_BITS-1:0] == '0)
                        nb_reg <= NBW'(1);
                    else if (int'(cfg_data[CFG_BANDS_BITS-1:0]) > MAX_BANDS)
                        nb_reg <= NBW'(MAX_BANDS);
                    else
                        nb_reg <= NBW'(cfg_data[CFG_BANDS_BITS-1:0]);
                end
                default:
                begin
                    nb_reg <= nb_reg;
                end
            endcase
        end
    end

    // left sample of each band's pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                hold_sum_reg[i] <= '0;
                hold_cnt_reg[i] <= 1'b0;
            end
        end
        else if (accept && col_reg[0] == 1'b0)
        begin
            hold_sum_reg[band_reg] <= s_in;
            hold_cnt_reg[band_reg] <= v_in;
        end
    end

    // upper line pair store
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            line_mem[addr] <= pair;
        if (accept)
            rd_reg <= line_mem[addr];
    end

    // stage 1
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && produce)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            s1_pair_reg  <= pair;
            s1_upper_reg <= row_reg[0];
            s1_eof_reg   <= last_row & last_col & last_band;
        end
    end

    // block sum and floor mean
    always_comb
    begin
        blk_sum = SUMW'(s1_pair_reg.sum);
        blk_cnt = {1'b0, s1_pair_reg.cnt};
        if (s1_upper_reg)
        begin
            blk_sum = blk_sum + SUMW'(rd_reg.sum);
            blk_cnt = blk_cnt + {1'b0, rd_reg.cnt};
        end
    end

    assign prod = PRODW'(blk_sum) * PRODW'(DIV3_MUL);

    always_comb
    begin
        unique case (blk_cnt)
            3'd1:    avg_calc = SB'(blk_sum);
            3'd2:    avg_calc = SB'(blk_sum >> 1);
            3'd3:    avg_calc = SB'(prod[PRODW-1:K]);
            3'd4:    avg_calc = SB'(blk_sum >> 2);
            default: avg_calc = '0;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            avg_reg  <= avg_calc;
            avgv_reg <= blk_cnt != 3'd0;
            last_reg <= s1_eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(avg_reg);
    assign m_tuser  = avgv_reg;
    assign m_tlast  = last_reg;

    a_empty_block_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty block result not zero");

    a_cfg_restart : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> col_reg == '0 && row_reg == '0 && band_reg == '0)
        else $error("register write did not restart position");

    a_band_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (NBW + 1)'(band_reg) < {1'b0, nb_reg})
        else $error("band index past band count");

    a_col_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (WEW + 1)'(col_reg) < {1'b0, w_reg})
        else $error("column past line width");

    a_s1_held : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_tvalid && !m_tready |=> s1_valid_reg)
        else $error("stage 1 word lost under stall");

endmodule
